// ===== src/sbsv_pkg.sv =====
// Package for the shielded bundle stream validator.
// Holds the parse phase type, key compare codes, status codes and varint prefix constants; no dependencies.
`default_nettype none
package sbsv_pkg;

  typedef enum logic [4:0] {
    PH_BAL, PH_SCOUNT, PH_SKEY, PH_SANCHOR, PH_SCV, PH_SPLEN, PH_SPBODY,
    PH_OCOUNT, PH_OKEY, PH_OCV, PH_ONLEN, PH_ONBODY, PH_OPLEN, PH_OPBODY,
    PH_RLEN, PH_RBODY, PH_BVK, PH_SIG, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMP_EQUAL   = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_TRAILING = 2'd2;
  localparam logic [1:0] ST_ORDER    = 2'd3;

  localparam logic [7:0] VI_MIN_PREFIX = 8'd253;
  localparam logic [7:0] VI_PREFIX_16  = 8'hFD;
  localparam logic [7:0] VI_PREFIX_32  = 8'hFE;
  localparam logic [63:0] VI_MAX_16    = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] VI_MAX_32    = 64'h0000_0000_FFFF_FFFF;

endpackage
`default_nettype wire

// ===== src/shielded_bundle_stream_validator_core.sv =====
// Shielded bundle stream validator: checks a serialized bundle at most one byte per item.
// Latency: the result of an is_last item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; a registered result stage with its own valid bit
// lets a new item in while the result is taken, and only a held result stalls input.
// Reset (rst_n low, synchronous) restarts the parse on the balance field.
// Depends on sbsv_pkg.
`default_nettype none
module shielded_bundle_stream_validator_core
  import sbsv_pkg::*;
#(
  parameter int KEY_BYTES    = 32,
  parameter int COMMIT_BYTES = 33,
  parameter int SIG_BYTES    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic signed [63:0] out_value_balance,
  output logic [63:0]      out_spend_count,
  output logic [63:0]      out_output_count
);

  localparam int KW = $clog2(KEY_BYTES) > 0 ? $clog2(KEY_BYTES) : 1;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [63:0] vacc_r, vacc_nxt;
  logic [63:0] recs_r, recs_nxt;
  logic [63:0] blob_r, blob_nxt;
  cmp_t        cmp_r, cmp_nxt;
  logic        havep_r, havep_nxt;
  logic        obad_r, obad_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [63:0] bal_r, bal_nxt;
  logic [63:0] stot_r, stot_nxt;
  logic [63:0] otot_r, otot_nxt;

  // Previous key store, one byte per position.
  logic [7:0] pkey_r [KEY_BYTES];
  logic [7:0] pkey_rd;
  logic [KW-1:0] kidx;
  logic       key_wr;

  logic accept;
  logic emit;
  logic [1:0] status_nxt;

  assign accept  = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign emit    = accept && in_is_last;
  assign kidx    = idx_r[KW-1:0];
  assign pkey_rd = pkey_r[kidx];

  // Byte consumption: one phase step per item.
  always_comb begin
    logic        vdone;
    logic [63:0] vval;
    logic [63:0] vacc_new;
    logic [3:0]  vlen;
    logic [63:0] recs_dec;
    logic [63:0] blob_dec;
    phase_t      dest;

    phase_nxt = phase_r; idx_nxt = idx_r; prefix_nxt = prefix_r; vacc_nxt = vacc_r;
    recs_nxt = recs_r; blob_nxt = blob_r; cmp_nxt = cmp_r; havep_nxt = havep_r;
    obad_nxt = obad_r; err_nxt = err_r; bal_nxt = bal_r; stot_nxt = stot_r;
    otot_nxt = otot_r; key_wr = 1'b0;
    vdone = 1'b0; vval = 64'd0; vacc_new = 64'd0; dest = phase_r;
    recs_dec = recs_r - 64'd1;
    blob_dec = blob_r - 64'd1;
    vlen = (prefix_r == VI_PREFIX_16) ? 4'd2 : ((prefix_r == VI_PREFIX_32) ? 4'd4 : 4'd8);

    if (accept && in_has_byte && err_r == ST_OK) begin
      case (phase_r)
        PH_BAL: begin
          bal_nxt = bal_r | ({56'd0, in_data_byte} << {idx_r[2:0], 3'b000});
          idx_nxt = idx_r + 7'd1;
          if (idx_nxt >= 7'd8) begin
            phase_nxt = PH_SCOUNT; idx_nxt = '0;
          end
        end
        PH_SCOUNT, PH_SPLEN, PH_OCOUNT, PH_ONLEN, PH_OPLEN, PH_RLEN: begin
          if (prefix_r == 8'd0) begin
            if (in_data_byte < VI_MIN_PREFIX) begin
              vdone = 1'b1; vval = {56'd0, in_data_byte};
            end else begin
              prefix_nxt = in_data_byte; idx_nxt = '0; vacc_nxt = '0;
            end
          end else begin
            vacc_new = vacc_r | ({56'd0, in_data_byte} << {idx_r[2:0], 3'b000});
            vacc_nxt = vacc_new;
            idx_nxt = idx_r + 7'd1;
            if (idx_nxt >= {3'd0, vlen}) begin
              if ((vlen == 4'd2 && vacc_new < {56'd0, VI_MIN_PREFIX}) ||
                  (vlen == 4'd4 && vacc_new <= VI_MAX_16) ||
                  (vlen == 4'd8 && vacc_new <= VI_MAX_32)) begin
                err_nxt = ST_TRUNC;
              end else begin
                vdone = 1'b1; vval = vacc_new;
              end
            end
          end
          if (vdone) begin
            case (phase_r)
              PH_SCOUNT: begin
                stot_nxt = vval; recs_nxt = vval; havep_nxt = 1'b0;
                dest = (vval == 64'd0) ? PH_OCOUNT : PH_SKEY;
              end
              PH_SPLEN: begin
                blob_nxt = vval;
                if (vval == 64'd0) begin
                  recs_nxt = recs_dec;
                  dest = (recs_dec == 64'd0) ? PH_OCOUNT : PH_SKEY;
                end else dest = PH_SPBODY;
              end
              PH_OCOUNT: begin
                otot_nxt = vval; recs_nxt = vval; havep_nxt = 1'b0;
                dest = (vval == 64'd0) ? PH_RLEN : PH_OKEY;
              end
              PH_ONLEN: begin
                blob_nxt = vval;
                dest = (vval == 64'd0) ? PH_OPLEN : PH_ONBODY;
              end
              PH_OPLEN: begin
                blob_nxt = vval;
                if (vval == 64'd0) begin
                  recs_nxt = recs_dec;
                  dest = (recs_dec == 64'd0) ? PH_RLEN : PH_OKEY;
                end else dest = PH_OPBODY;
              end
              default: begin
                blob_nxt = vval;
                dest = (vval == 64'd0) ? PH_BVK : PH_RBODY;
              end
            endcase
            phase_nxt = dest; idx_nxt = '0; prefix_nxt = '0; vacc_nxt = '0;
          end
        end
        PH_SKEY, PH_OKEY: begin
          if (havep_r && cmp_r == CMP_EQUAL) begin
            if (in_data_byte > pkey_rd) cmp_nxt = CMP_GREATER;
            else if (in_data_byte < pkey_rd) cmp_nxt = CMP_LESS;
          end
          key_wr = 1'b1;
          idx_nxt = idx_r + 7'd1;
          if (idx_nxt >= 7'(KEY_BYTES)) begin
            if (havep_r && cmp_nxt != CMP_GREATER) obad_nxt = 1'b1;
            havep_nxt = 1'b1; cmp_nxt = CMP_EQUAL; idx_nxt = '0;
            phase_nxt = (phase_r == PH_SKEY) ? PH_SANCHOR : PH_OCV;
          end
        end
        PH_SANCHOR, PH_SCV, PH_OCV, PH_BVK, PH_SIG: begin
          idx_nxt = idx_r + 7'd1;
          case (phase_r)
            PH_SANCHOR: if (idx_nxt >= 7'(KEY_BYTES)) dest = PH_SCV;
            PH_SCV:     if (idx_nxt >= 7'(COMMIT_BYTES)) dest = PH_SPLEN;
            PH_OCV:     if (idx_nxt >= 7'(COMMIT_BYTES)) dest = PH_ONLEN;
            PH_BVK:     if (idx_nxt >= 7'(COMMIT_BYTES)) dest = PH_SIG;
            // The signature may be 128 bytes long, so its count is taken one bit wider.
            default:    if (({1'b0, idx_r} + 8'd1) >= 8'(SIG_BYTES)) dest = PH_DONE;
          endcase
          if (dest != phase_r) begin
            phase_nxt = dest; idx_nxt = '0;
          end
        end
        PH_SPBODY, PH_ONBODY, PH_OPBODY, PH_RBODY: begin
          blob_nxt = blob_dec;
          if (blob_dec == 64'd0) begin
            case (phase_r)
              PH_SPBODY: begin
                recs_nxt = recs_dec;
                dest = (recs_dec == 64'd0) ? PH_OCOUNT : PH_SKEY;
              end
              PH_ONBODY: dest = PH_OPLEN;
              PH_OPBODY: begin
                recs_nxt = recs_dec;
                dest = (recs_dec == 64'd0) ? PH_RLEN : PH_OKEY;
              end
              default: dest = PH_BVK;
            endcase
            phase_nxt = dest; idx_nxt = '0;
          end
        end
        default: err_nxt = ST_TRAILING;
      endcase
    end

    // Status after this item's byte.
    if (err_nxt != ST_OK) status_nxt = err_nxt;
    else if (phase_nxt != PH_DONE) status_nxt = ST_TRUNC;
    else if (obad_nxt) status_nxt = ST_ORDER;
    else status_nxt = ST_OK;
  end

  // Parser state register; an is_last item restarts the parse.
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      phase_r <= PH_BAL; idx_r <= '0; prefix_r <= '0; vacc_r <= '0;
      recs_r <= '0; blob_r <= '0; cmp_r <= CMP_EQUAL; havep_r <= 1'b0;
      obad_r <= 1'b0; err_r <= ST_OK; bal_r <= '0; stot_r <= '0; otot_r <= '0;
    end else begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; prefix_r <= prefix_nxt;
      vacc_r <= vacc_nxt; recs_r <= recs_nxt; blob_r <= blob_nxt; cmp_r <= cmp_nxt;
      havep_r <= havep_nxt; obad_r <= obad_nxt; err_r <= err_nxt; bal_r <= bal_nxt;
      stot_r <= stot_nxt; otot_r <= otot_nxt;
    end
  end

  // Previous key store.
  always_ff @(posedge clk) begin
    if (key_wr) pkey_r[kidx] <= in_data_byte;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status        <= status_nxt;
      out_value_balance <= bal_nxt;
      out_spend_count   <= stot_nxt;
      out_output_count  <= otot_nxt;
    end
  end

`ifndef SYNTHESIS
  // A waiting result that is not taken blocks new items.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a held result");

  // A result appears only after an is_last item.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(accept && in_is_last))
    else $error("result without end mark");

  // A sticky error freezes the parse phase.
  a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_OK && !emit |=> $stable(phase_r))
    else $error("phase moved after an error");

  // Key compare is only left at equal outside key fields.
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_SKEY && phase_r != PH_OKEY |-> cmp_r == CMP_EQUAL)
    else $error("stale key compare");
`endif

endmodule
`default_nettype wire
